/* rtl/scp_pkg.sv */
`timescale 1ns / 1ps

package scp_pkg;

   localparam int ANGLE_W   = 32;
   localparam int VALUE_W   = 32;
   // Q4.28 working width, with headroom for x^2 at |x| = pi
   localparam int POLY_W    = 34;
   localparam int PROD_W    = 2 * POLY_W;
   localparam int FRAC_BITS = 28;
   // Q8.24 -> Q4.28
   localparam int WIDEN_SHIFT = 4;
   // Q4.28 -> Q2.30
   localparam int OUT_SHIFT   = 2;

   // Whole turns that can be removed from a 32-bit Q8.24 angle on either side
   localparam int NUM_TURNS = 20;

   // reduction (2) + four multiply steps (2 each) + output register
   localparam int PIPE_DEPTH = 11;

   localparam longint PI_Q24     = 64'sd52707178;
   localparam longint TWO_PI_Q24 = 64'sd105414357;

   localparam logic signed [POLY_W-1:0] ONE_Q28  = 34'sd268435456;
   localparam logic signed [POLY_W-1:0] HALF_Q28 = 34'sd134217728;
   localparam logic signed [POLY_W-1:0] C4_Q28   = 34'sd11184811;
   localparam logic signed [POLY_W-1:0] C6_Q28   = 34'sd372827;
   localparam logic signed [POLY_W-1:0] S3_Q28   = 34'sd44739244;
   localparam logic signed [POLY_W-1:0] S5_Q28   = 34'sd2236962;

   localparam logic FUNC_COS = 1'b0;
   localparam logic FUNC_SIN = 1'b1;

   // Sideband that rides along the multiply steps
   typedef struct packed {
      logic                     func;
      logic signed [POLY_W-1:0] x;
      logic signed [POLY_W-1:0] x2;
   } scp_side_type;

   // Angle above which j+1 turns are removed (mirrored for the negative side)
   function automatic logic signed [POLY_W-1:0] turn_bound(input int j);
      turn_bound = POLY_W'(PI_Q24 + longint'(j) * TWO_PI_Q24);
   endfunction

   // Amount removed when j+1 turns come off
   function automatic logic signed [POLY_W-1:0] turn_offset(input int j);
      turn_offset = POLY_W'(longint'(j + 1) * TWO_PI_Q24);
   endfunction

endpackage

/* rtl/scp_reduce.sv */
`timescale 1ns / 1ps

module scp_reduce
   import scp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic                      in_func,
   input  logic signed [ANGLE_W-1:0] in_angle,
   output logic                      out_valid,
   output logic                      out_func,
   output logic signed [POLY_W-1:0]  out_x
);

   logic                      s1_valid_ff;
   logic                      s1_func_ff;
   logic signed [ANGLE_W-1:0] s1_angle_ff;
   logic [NUM_TURNS-1:0]      pos_hit_in, pos_hit_ff;
   logic [NUM_TURNS-1:0]      neg_hit_in, neg_hit_ff;

   logic                      s2_valid_ff;
   logic                      s2_func_ff;
   logic signed [POLY_W-1:0]  s2_x_in, s2_x_ff;

   // Stage 1: compare against every turn boundary in parallel (thermometer code)
   always_comb begin
      logic signed [POLY_W-1:0] angle_ext;
      angle_ext = POLY_W'(in_angle);
      for (int j = 0; j < NUM_TURNS; j++) begin
         pos_hit_in[j] = angle_ext > turn_bound(j);
         neg_hit_in[j] = angle_ext < -turn_bound(j);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      s1_func_ff  <= in_func;
      s1_angle_ff <= in_angle;
      pos_hit_ff  <= pos_hit_in;
      neg_hit_ff  <= neg_hit_in;
   end

   // Stage 2: top bit of the thermometer picks the offset, then widen to Q4.28
   always_comb begin
      logic [NUM_TURNS-1:0]     pos_top;
      logic [NUM_TURNS-1:0]     neg_top;
      logic signed [POLY_W-1:0] off_pos;
      logic signed [POLY_W-1:0] off_neg;
      logic signed [POLY_W-1:0] x_red;
      pos_top = pos_hit_ff & ~(pos_hit_ff >> 1);
      neg_top = neg_hit_ff & ~(neg_hit_ff >> 1);
      off_pos = '0;
      off_neg = '0;
      for (int j = 0; j < NUM_TURNS; j++) begin
         off_pos = off_pos | (pos_top[j] ? turn_offset(j) : '0);
         off_neg = off_neg | (neg_top[j] ? turn_offset(j) : '0);
      end
      x_red   = POLY_W'(s1_angle_ff) - off_pos + off_neg;
      s2_x_in = x_red <<< WIDEN_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_func_ff <= s1_func_ff;
      s2_x_ff    <= s2_x_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_func  = s2_func_ff;
   assign out_x     = s2_x_ff;

endmodule

/* rtl/scp_step.sv */
`timescale 1ns / 1ps

// One Horner step: result = sub ? addend - qmul(a, b) : qmul(a, b)
// qmul rounds to nearest, halves away from zero. The product and the result are each registered.
module scp_step
   import scp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  scp_side_type             in_side,
   input  logic signed [POLY_W-1:0] in_a,
   input  logic signed [POLY_W-1:0] in_b,
   input  logic signed [POLY_W-1:0] in_addend,
   input  logic                     in_sub,
   output logic                     out_valid,
   output scp_side_type             out_side,
   output logic signed [POLY_W-1:0] out_result
);

   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_BITS - 1);

   logic                     m_valid_ff;
   scp_side_type             m_side_ff;
   logic signed [PROD_W-1:0] m_prod_ff;
   logic signed [POLY_W-1:0] m_addend_ff;
   logic                     m_sub_ff;

   logic                     r_valid_ff;
   scp_side_type             r_side_ff;
   logic signed [POLY_W-1:0] r_result_in, r_result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= in_valid;
      end
      m_side_ff   <= in_side;
      m_prod_ff   <= PROD_W'(in_a) * PROD_W'(in_b);
      m_addend_ff <= in_addend;
      m_sub_ff    <= in_sub;
   end

   // Negative products take one less of bias so that halves round away from zero
   always_comb begin
      logic signed [PROD_W-1:0] biased;
      logic signed [PROD_W-1:0] shifted;
      logic signed [POLY_W-1:0] rounded;
      biased  = m_prod_ff + (m_prod_ff[PROD_W-1] ? ROUND_HALF - PROD_W'(1) : ROUND_HALF);
      shifted = biased >>> FRAC_BITS;
      rounded = shifted[POLY_W-1:0];
      r_result_in = m_sub_ff ? m_addend_ff - rounded : rounded;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else begin
         r_valid_ff <= m_valid_ff;
      end
      r_side_ff   <= m_side_ff;
      r_result_ff <= r_result_in;
   end

   assign out_valid  = r_valid_ff;
   assign out_side   = r_side_ff;
   assign out_result = r_result_ff;

endmodule

/* rtl/sine_cosine_polynomial_core.sv */
`timescale 1ns / 1ps

// Sine / cosine of a Q8.24 angle by truncated Taylor polynomial, result in
// Q2.30 saturated. The angle is first folded into [-pi, pi] (exactly +-pi
// stays put). req_func = 0 gives cosine, 1 gives sine. The core is a fixed
// 11-stage pipeline: two stages of angle folding, four multiply steps of
// the Horner evaluation, each with a product and a result register, and an
// output register. It takes one item every clock while busy is low; each
// result appears on rsp_value with rsp_valid high for one cycle, in start
// order. There is no backpressure on the result side: the receiver must take
// every result as it shows. busy is high only while reset is held.
module sine_cosine_polynomial_core
   import scp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_func,
   input  logic signed [ANGLE_W-1:0] req_angle,
   output logic                      rsp_valid,
   output logic signed [VALUE_W-1:0] rsp_value
);

   localparam logic signed [POLY_W+OUT_SHIFT-1:0] SAT_MAX =
      (POLY_W + OUT_SHIFT)'(longint'(2147483647));
   localparam logic signed [POLY_W+OUT_SHIFT-1:0] SAT_MIN =
      (POLY_W + OUT_SHIFT)'(-64'sd2147483648);

   logic                     accept;
   logic                     red_valid;
   logic                     red_func;
   logic signed [POLY_W-1:0] red_x;

   scp_side_type             sq_side_in;
   logic                     sq_valid;
   scp_side_type             sq_side;
   logic signed [POLY_W-1:0] sq_result;
   scp_side_type             sq_side_out;

   logic                     t1_valid;
   scp_side_type             t1_side;
   logic signed [POLY_W-1:0] t1_result;
   logic signed [POLY_W-1:0] t1_b;
   logic signed [POLY_W-1:0] t1_addend;

   logic                     t2_valid;
   scp_side_type             t2_side;
   logic signed [POLY_W-1:0] t2_result;
   logic signed [POLY_W-1:0] t2_addend;

   logic                     fin_valid;
   scp_side_type             fin_side;
   logic signed [POLY_W-1:0] fin_result;
   logic signed [POLY_W-1:0] fin_a;
   logic                     fin_sub;

   logic                     out_valid_ff;
   logic signed [VALUE_W-1:0] out_value_in, out_value_ff;

   assign busy   = reset;
   assign accept = start & ~busy;

   scp_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_func   (req_func),
      .in_angle  (req_angle),
      .out_valid (red_valid),
      .out_func  (red_func),
      .out_x     (red_x)
   );

   // x^2
   always_comb begin
      sq_side_in.func = red_func;
      sq_side_in.x    = red_x;
      sq_side_in.x2   = '0;
   end

   scp_step u_square (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (red_valid),
      .in_side    (sq_side_in),
      .in_a       (red_x),
      .in_b       (red_x),
      .in_addend  ('0),
      .in_sub     (1'b0),
      .out_valid  (sq_valid),
      .out_side   (sq_side),
      .out_result (sq_result)
   );

   always_comb begin
      sq_side_out      = sq_side;
      sq_side_out.x2   = sq_result;
      t1_b      = (sq_side.func == FUNC_SIN) ? S5_Q28 : C6_Q28;
      t1_addend = (sq_side.func == FUNC_SIN) ? S3_Q28 : C4_Q28;
   end

   // innermost Horner term
   scp_step u_term1 (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (sq_valid),
      .in_side    (sq_side_out),
      .in_a       (sq_result),
      .in_b       (t1_b),
      .in_addend  (t1_addend),
      .in_sub     (1'b1),
      .out_valid  (t1_valid),
      .out_side   (t1_side),
      .out_result (t1_result)
   );

   assign t2_addend = (t1_side.func == FUNC_SIN) ? ONE_Q28 : HALF_Q28;

   scp_step u_term2 (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (t1_valid),
      .in_side    (t1_side),
      .in_a       (t1_side.x2),
      .in_b       (t1_result),
      .in_addend  (t2_addend),
      .in_sub     (1'b1),
      .out_valid  (t2_valid),
      .out_side   (t2_side),
      .out_result (t2_result)
   );

   // cosine: one - x2*t2, sine: x*t2
   assign fin_a   = (t2_side.func == FUNC_SIN) ? t2_side.x : t2_side.x2;
   assign fin_sub = (t2_side.func == FUNC_COS);

   scp_step u_final (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (t2_valid),
      .in_side    (t2_side),
      .in_a       (fin_a),
      .in_b       (t2_result),
      .in_addend  (ONE_Q28),
      .in_sub     (fin_sub),
      .out_valid  (fin_valid),
      .out_side   (fin_side),
      .out_result (fin_result)
   );

   always_comb begin
      logic signed [POLY_W+OUT_SHIFT-1:0] scaled;
      scaled = (POLY_W + OUT_SHIFT)'(fin_result) <<< OUT_SHIFT;
      if (scaled > SAT_MAX) begin
         out_value_in = SAT_MAX[VALUE_W-1:0];
      end else if (scaled < SAT_MIN) begin
         out_value_in = SAT_MIN[VALUE_W-1:0];
      end else begin
         out_value_in = scaled[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= fin_valid;
      end
      out_value_ff <= out_value_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_value = out_value_ff;

endmodule

/* rtl/scp_checker.sv */
`timescale 1ns / 1ps

module scp_checker
   import scp_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      req_func,
   input logic signed [ANGLE_W-1:0] req_angle,
   input logic                      rsp_valid,
   input logic signed [VALUE_W-1:0] rsp_value
);

   localparam logic signed [VALUE_W-1:0] ONE_Q30   = 32'sh4000_0000;
   localparam logic signed [VALUE_W-1:0] BOUND_Q30 = 32'sd1342177280;

   // every accepted item yields exactly one result
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_DEPTH rsp_valid)
      else $error("accepted item produced no result");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_DEPTH))
      else $error("result without a matching item");

   a_zero_angle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_angle == '0) |-> ##PIPE_DEPTH
      ((req_func == FUNC_SIN) ? rsp_value == '0 : rsp_value == ONE_Q30) ||
      ($past(req_func, PIPE_DEPTH) == FUNC_SIN ? rsp_value == '0 : rsp_value == ONE_Q30))
      else $error("wrong result for a zero angle");

   // folded angles keep both polynomials inside +-1.25
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_value <= BOUND_Q30) && (rsp_value >= -BOUND_Q30))
      else $error("result outside the reachable range");

endmodule

bind sine_cosine_polynomial_core scp_checker u_scp_checker (.*);
